### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion shorthands
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold at the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rgbf_pkg.sv
// ----------------------------------------------------------------------------
// rgbf_pkg - shared constants and types of the RGB color fade
// Field widths, reset values, action codes and the sequencer states.
// ----------------------------------------------------------------------------
package rgbf_pkg;

  localparam int unsigned ChannelBitsDef = 8;
  localparam int unsigned StepW          = 8;
  localparam int unsigned NumChan        = 3;

  localparam logic [StepW-1:0] FadeStepsReset = 8'd16;
  localparam logic [1:0]       LastChan       = 2'(NumChan - 1);

  localparam logic ActTarget = 1'b0;
  localparam logic ActTick   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_WAIT,
    ST_WRITE
  } fade_state_e;

endpackage

### design/rgbf_div.sv
// ----------------------------------------------------------------------------
// rgbf_div - restoring divider, one quotient bit per cycle
// Quotient must fit ChannelBits bits (dividend < divisor << ChannelBits).
// ----------------------------------------------------------------------------
module rgbf_div #(
  parameter int unsigned ChannelBits = rgbf_pkg::ChannelBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [ChannelBits+rgbf_pkg::StepW-1:0]  dividend_i,
  input  logic [rgbf_pkg::StepW-1:0]              divisor_i,
  output logic [ChannelBits-1:0]                  quotient_o,
  output logic                                    done_o
);
  import rgbf_pkg::*;

  localparam int unsigned CntW = $clog2(ChannelBits + 1);

  logic [StepW-1:0]       rem_q, rem_d;
  logic [ChannelBits-1:0] quo_q, quo_d;
  logic [StepW-1:0]       dsr_q;
  logic [CntW-1:0]        cnt_q;
  logic                   run_q;
  logic                   done_q;
  logic [StepW:0]         shifted;
  logic                   ge;

  always_comb begin
    shifted = {rem_q, quo_q[ChannelBits-1]};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = ge ? StepW'(shifted - {1'b0, dsr_q}) : shifted[StepW-1:0];
    quo_d   = {quo_q[ChannelBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(ChannelBits);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper part of the dividend is already below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[ChannelBits+StepW-1:ChannelBits];
      quo_q <= dividend_i[ChannelBits-1:0];
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### design/rgb_linear_color_fade.sv
// ----------------------------------------------------------------------------
// rgb_linear_color_fade - linear RGB fade over a configured number of steps
// Each step runs the channels in turn through the shared bit-serial divider:
// multiply, load the divider, wait for the quotient, then write the result;
// the input stalls while a step is computed. A retarget during a fade or an
// idle tick gives no result; a retarget while idle starts the first step.
// Reset: idle, shown color full red, fade_steps 16; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_linear_color_fade #(
  parameter int unsigned ChannelBits = rgbf_pkg::ChannelBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rgbf_pkg::StepW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [ChannelBits-1:0]      target_red_i,
  input  logic [ChannelBits-1:0]      target_green_i,
  input  logic [ChannelBits-1:0]      target_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ChannelBits-1:0]      out_red_o,
  output logic [ChannelBits-1:0]      out_green_o,
  output logic [ChannelBits-1:0]      out_blue_o,
  output logic                        still_fading_o
);
  import rgbf_pkg::*;

  localparam int unsigned ProdW = ChannelBits + StepW;

  typedef logic [ChannelBits-1:0] chan_t;

  fade_state_e state_q, state_d;

  logic [StepW-1:0] fade_q;
  chan_t            start_q [NumChan];
  chan_t            goal_q  [NumChan];
  chan_t            shown_q [NumChan];
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [1:0]       ch_q;
  logic [ProdW-1:0] prod_q;
  logic             out_valid_q;
  chan_t            out_red_q, out_green_q, out_blue_q;
  logic             out_fading_q;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             div_start;
  logic             div_done;
  chan_t            div_quo;

  logic [StepW-1:0] steps_eff;
  logic [StepW:0]   num_raw;
  logic             last;
  logic [StepW-1:0] num_eff;
  chan_t            sel_start, sel_goal, mag, value;
  logic             neg;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // step index and divisor; zero steps acts as one
  always_comb begin
    steps_eff = (fade_q == '0) ? StepW'(1) : fade_q;
    num_raw   = {1'b0, step_q} + (StepW+1)'(1);
    last      = num_raw >= {1'b0, steps_eff};
    num_eff   = last ? steps_eff : num_raw[StepW-1:0];
  end

  // per-channel operands; the divider works on the magnitude
  always_comb begin
    sel_start = start_q[ch_q];
    sel_goal  = goal_q[ch_q];
    neg       = sel_goal < sel_start;
    mag       = neg ? sel_start - sel_goal : sel_goal - sel_start;
    value     = neg ? sel_start - div_quo : sel_start + div_quo;
  end

  rgbf_div #(
    .ChannelBits(ChannelBits)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (steps_eff),
    .quotient_o(div_quo),
    .done_o    (div_done)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ActTick) begin
            if (busy_q) state_d = ST_MUL;
          end else if (!busy_q) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_done) state_d = (ch_q == LastChan) ? ST_WRITE : ST_MUL;
      end
      ST_WRITE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state_q == ST_LOAD);
    out_load  = (state_q == ST_WRITE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fade_q      <= FadeStepsReset;
      busy_q      <= 1'b0;
      step_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumChan; c++) begin
        start_q[c] <= '0;
        goal_q[c]  <= '0;
        shown_q[c] <= (c == 0) ? '1 : '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) fade_q <= cfg_wdata_i;

      if (in_acc) begin
        ch_q <= '0;
        if (action_i == ActTarget) begin
          goal_q[0] <= target_red_i;
          goal_q[1] <= target_green_i;
          goal_q[2] <= target_blue_i;
          step_q    <= '0;
          if (!busy_q) begin
            busy_q  <= 1'b1;
            start_q <= shown_q;
          end
        end
      end

      if (state_q == ST_WAIT && div_done) begin
        shown_q[ch_q] <= value;
        ch_q          <= (ch_q == LastChan) ? 2'd0 : ch_q + 2'd1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        step_q      <= step_q + StepW'(1);
        if (last) busy_q <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) prod_q <= ProdW'(mag) * ProdW'(num_eff);
    if (out_load) begin
      out_red_q    <= shown_q[0];
      out_green_q  <= shown_q[1];
      out_blue_q   <= shown_q[2];
      out_fading_q <= !last;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_red_q;
  assign out_green_o    = out_green_q;
  assign out_blue_o     = out_blue_q;
  assign still_fading_o = out_fading_q;

`include "assert_macros.svh"

  `ASSERT_NOW(a_calc_in_fade, (state_q == ST_IDLE) || busy_q, "step computed outside a fade")
  `ASSERT_NOW(a_chan_range, ch_q <= LastChan, "channel index out of range")
  `ASSERT_NEXT(a_last_ends, out_load && last, !busy_q && (state_q == ST_IDLE), "final step did not end fade")
  `ASSERT_NEXT(a_retarget_quiet, in_acc && (action_i == ActTarget) && busy_q, (state_q == ST_IDLE) && (step_q == '0), "retarget during fade started a step")

endmodule
